// ===== rtl/sate_pkg.sv =====
`default_nettype none
package sate_pkg;

  localparam int unsigned DefCapacity = 128;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_READ   = 3'd2,
    ACT_PARITY = 3'd3,
    ACT_MAX    = 3'd4,
    ACT_INSERT = 3'd5,
    ACT_DELETE = 3'd6,
    ACT_SORT   = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_RD_WAIT, S_WALK_RD, S_WALK_USE,
    S_INS_RD, S_INS_WR, S_INS_LAST,
    S_DEL_RD, S_DEL_CMP, S_SH_RD, S_SH_WR,
    S_SL_RD, S_SL_USE, S_SO_RD, S_SO_USE, S_SO_END,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [6:0]         position;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [7:0]         even_tally;
    logic [7:0]         odd_tally;
    logic [7:0]         element_count;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/sate_if.sv =====
`default_nettype none
interface sate_in_if;
  import sate_pkg::*;
  logic valid;
  logic ready;
  in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sate_out_if;
  import sate_pkg::*;
  logic valid;
  logic ready;
  out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/small_array_table_engine_core.sv =====
`default_nettype none
// Clear and append are done in dispatch; read, parity, max, insert, delete and sort are
// sequenced through the element memory (one registered read and one write per cycle),
// walked by the sequencer; sort leaves the table as it is with fewer than two elements.
// Throughput: one transaction at a time; input ready only while the sequencer is idle.
// Reset (asynchronous, active low) empties the table; memory contents are not cleared.
module small_array_table_engine_core #(
  parameter int unsigned CAPACITY = sate_pkg::DefCapacity
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sate_in_if.sink     in_i,
  sate_out_if.source  out_o
);
  import sate_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 7) ? CW : 7;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_q;
  logic [AW-1:0]      raddr, waddr;
  logic signed [31:0] wdata;
  logic               we;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  state_e             state_q, state_d;
  logic [2:0]         act_q, act_d;
  logic signed [31:0] val_q, val_d;
  logic [6:0]         pos_q, pos_d;
  logic [CW-1:0]      n_q, n_d, idx_q, idx_d, lim_q, lim_d, even_q, even_d, odd_q, odd_d;
  logic signed [31:0] acc_q, acc_d, cur_q, cur_d;
  status_e            st_q, st_d;
  logic               ov_q, ov_d;
  out_t               out_q, out_d;

  logic [CW-1:0] idx_inc, idx_dec;
  logic [PW-1:0] pos_w, n_w;

  assign idx_inc = idx_q + CW'(1);
  assign idx_dec = idx_q - CW'(1);
  assign pos_w   = PW'(pos_q);
  assign n_w     = PW'(n_q);

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = ov_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    val_q  <= val_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    lim_q  <= lim_d;
    even_q <= even_d;
    odd_q  <= odd_d;
    acc_q  <= acc_d;
    cur_q  <= cur_d;
    st_q   <= st_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    val_d   = val_q;
    pos_d   = pos_q;
    n_d     = n_q;
    idx_d   = idx_q;
    lim_d   = lim_q;
    even_d  = even_q;
    odd_d   = odd_q;
    acc_d   = acc_q;
    cur_d   = cur_q;
    st_d    = st_q;
    ov_d    = ov_q;
    out_d   = out_q;
    raddr   = idx_q[AW-1:0];
    waddr   = idx_q[AW-1:0];
    wdata   = rdata_q;
    we      = 1'b0;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.payload.action;
          val_d   = in_i.payload.value;
          pos_d   = in_i.payload.position;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_d    = ST_OK;
        acc_d   = '0;
        even_d  = '0;
        odd_d   = '0;
        idx_d   = '0;
        state_d = S_DONE;
        case (action_e'(act_q))
          ACT_CLEAR: n_d = '0;
          ACT_APPEND: begin
            if (n_q == CW'(CAPACITY)) begin
              st_d = ST_FULL;
            end else begin
              we    = 1'b1;
              waddr = n_q[AW-1:0];
              wdata = val_q;
              n_d   = n_q + CW'(1);
            end
          end
          ACT_READ: begin
            if (n_q == '0) begin
              st_d = ST_EMPTY;
            end else if (pos_w >= n_w) begin
              st_d = ST_BADPOS;
            end else begin
              raddr   = pos_w[AW-1:0];
              state_d = S_RD_WAIT;
            end
          end
          ACT_PARITY: begin
            if (n_q != '0) state_d = S_WALK_RD;
          end
          ACT_MAX: begin
            if (n_q == '0) st_d = ST_EMPTY;
            else state_d = S_WALK_RD;
          end
          ACT_INSERT: begin
            if (n_q == CW'(CAPACITY)) begin
              st_d = ST_FULL;
            end else begin
              idx_d   = n_q;
              state_d = (n_q == '0) ? S_INS_LAST : S_INS_RD;
            end
          end
          ACT_DELETE: begin
            if (n_q == '0) st_d = ST_EMPTY;
            else state_d = S_DEL_RD;
          end
          ACT_SORT: begin
            lim_d = n_q;
            if (n_q > CW'(1)) state_d = S_SL_RD;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RD_WAIT: begin
        acc_d   = rdata_q;
        state_d = S_DONE;
      end
      S_WALK_RD: state_d = S_WALK_USE;
      S_WALK_USE: begin
        if (act_q == ACT_PARITY) begin
          if (rdata_q[0]) odd_d = odd_q + CW'(1);
          else even_d = even_q + CW'(1);
        end else if (idx_q == '0 || rdata_q > acc_q) begin
          acc_d = rdata_q;
        end
        idx_d   = idx_inc;
        state_d = (idx_inc == n_q) ? S_DONE : S_WALK_RD;
      end
      S_INS_RD: begin
        raddr   = idx_dec[AW-1:0];
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        we      = 1'b1;
        idx_d   = idx_dec;
        state_d = (idx_dec == '0) ? S_INS_LAST : S_INS_RD;
      end
      S_INS_LAST: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        n_d     = n_q + CW'(1);
        state_d = S_DONE;
      end
      S_DEL_RD: state_d = S_DEL_CMP;
      S_DEL_CMP: begin
        idx_d = idx_inc;
        if (rdata_q == val_q) begin
          if (idx_inc == n_q) begin
            n_d     = n_q - CW'(1);
            state_d = S_DONE;
          end else begin
            state_d = S_SH_RD;
          end
        end else if (idx_inc == n_q) begin
          st_d    = ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          state_d = S_DEL_RD;
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: begin
        // close the gap: element at idx moves down one place
        we    = 1'b1;
        waddr = idx_dec[AW-1:0];
        idx_d = idx_inc;
        if (idx_inc == n_q) begin
          n_d     = n_q - CW'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_SH_RD;
        end
      end
      S_SL_RD: begin
        raddr   = '0;
        state_d = S_SL_USE;
      end
      S_SL_USE: begin
        cur_d   = rdata_q;
        idx_d   = CW'(1);
        state_d = S_SO_RD;
      end
      S_SO_RD: state_d = S_SO_USE;
      S_SO_USE: begin
        // carry the smaller word forward so the pass sinks the minimum to the end
        we    = 1'b1;
        waddr = idx_dec[AW-1:0];
        if (rdata_q > cur_q) begin
          wdata = rdata_q;
        end else begin
          wdata = cur_q;
          cur_d = rdata_q;
        end
        idx_d   = idx_inc;
        state_d = (idx_inc == lim_q) ? S_SO_END : S_SO_RD;
      end
      S_SO_END: begin
        we      = 1'b1;
        waddr   = idx_dec[AW-1:0];
        wdata   = cur_q;
        lim_d   = lim_q - CW'(1);
        state_d = (lim_q == CW'(2)) ? S_DONE : S_SL_RD;
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d                = 1'b1;
          out_d.status        = st_q;
          out_d.data          = acc_q;
          out_d.even_tally    = 8'(even_q);
          out_d.odd_tally     = 8'(odd_q);
          out_d.element_count = 8'(n_q);
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
